// ===== rtl/cgts_pkg.sv =====
`timescale 1ns / 1ps
package cgts_pkg;

  localparam int TYPE_W  = 5;
  localparam int TIMER_W = 8;
  localparam int TOTAL_W = 21;
  localparam int SLOT_W  = 32;

  typedef enum logic {
    KIND_ADD  = 1'b0,
    KIND_TICK = 1'b1
  } kind_t;

endpackage

// ===== rtl/cgts_in_if.sv =====
`timescale 1ns / 1ps
interface cgts_in_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [cgts_pkg::TYPE_W-1:0]  task_type;

  modport source (output valid, output kind, output task_type, input ready);
  modport sink   (input valid, input kind, input task_type, output ready);
endinterface

// ===== rtl/cgts_out_if.sv =====
`timescale 1ns / 1ps
interface cgts_out_if;
  logic                          valid;
  logic                          ready;
  logic [cgts_pkg::TYPE_W-1:0]   chosen_type;
  logic [cgts_pkg::SLOT_W-1:0]   slot_count;
  logic [cgts_pkg::TOTAL_W-1:0]  remaining;
  logic                          done_res;

  modport source (output valid, output chosen_type, output slot_count,
                  output remaining, output done_res, input ready);
  modport sink   (input valid, input chosen_type, input slot_count,
                  input remaining, input done_res, output ready);
endinterface

// ===== rtl/cgts_cfg_if.sv =====
`timescale 1ns / 1ps
interface cgts_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [cgts_pkg::TIMER_W-1:0]  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/cgts_ram.sv =====
`timescale 1ns / 1ps
module cgts_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 26
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/cooldown_greedy_task_scheduler.sv =====
`timescale 1ns / 1ps
// Greedy scheduler with a per-type cooldown. Per-type pending counts and
// cooldown timers live in one dual-port RAM (one write, one registered read
// port); per-entry valid flops make all entries read as zero after reset, so
// no clearing pass is needed. An add reads its entry, then does the
// read-modify-write. A tick with work pending walks every RAM entry once
// through the read port, one per cycle, picking the ready type with the
// largest count and writing back each entry's decremented timer; S_FIN then
// updates the chosen entry and S_EMIT registers the result once the output
// register is free. A tick with nothing pending goes straight to S_EMIT. The
// result sits in an output register, so the next item can be taken while it waits.
// The cooldown register should only be written while the block is idle.
module cooldown_greedy_task_scheduler #(
  parameter int NUM_TYPES   = 26,
  parameter int COUNT_WIDTH = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  cgts_in_if.sink      in_ch,
  cgts_out_if.source   out_ch,
  cgts_cfg_if.sink     cfg_ch
);

  localparam int ADDR_W  = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam int IDX_W   = $clog2(NUM_TYPES + 1);
  localparam int TIMER_W = cgts_pkg::TIMER_W;
  localparam int TOTAL_W = cgts_pkg::TOTAL_W;
  localparam int SLOT_W  = cgts_pkg::SLOT_W;
  localparam int TYPE_W  = cgts_pkg::TYPE_W;
  localparam int ENTRY_W = COUNT_WIDTH + TIMER_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_SCAN,
    S_FIN,
    S_EMIT
  } state_t;

  state_t state_r;

  logic [TIMER_W-1:0]     cooldown_r;
  logic [TOTAL_W-1:0]     total_r;
  logic [SLOT_W-1:0]      slots_r;
  logic [NUM_TYPES-1:0]   valid_r;
  logic                   rd_vld_r;
  logic [ADDR_W-1:0]      scan_idx_r;
  logic [ADDR_W-1:0]      add_addr_r;
  logic [IDX_W-1:0]       best_r;
  logic [COUNT_WIDTH-1:0] best_cnt_r;

  logic                   out_valid_r;
  logic [TYPE_W-1:0]      out_type_r;
  logic [SLOT_W-1:0]      out_slots_r;
  logic [TOTAL_W-1:0]     out_total_r;
  logic                   out_done_r;

  // RAM ports
  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [ENTRY_W-1:0]     ram_wdata;
  logic [ADDR_W-1:0]      ram_raddr;
  logic [ENTRY_W-1:0]     ram_rdata;

  cgts_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_TYPES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Never-written entries read as zero.
  logic [ENTRY_W-1:0]     entry;
  logic [COUNT_WIDTH-1:0] ent_cnt;
  logic [TIMER_W-1:0]     ent_tmr;
  assign entry   = rd_vld_r ? ram_rdata : '0;
  assign ent_cnt = entry[ENTRY_W-1:TIMER_W];
  assign ent_tmr = entry[TIMER_W-1:0];

  logic in_fire;
  logic add_ok;
  logic [ADDR_W+TYPE_W-1:0] type_m1;
  logic add_room;
  logic cand;
  logic last_idx;
  logic [IDX_W-1:0] scan_num;
  logic [IDX_W+TYPE_W-1:0] best_ext;
  logic out_free;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign add_ok   = (in_ch.task_type != '0) && (int'(in_ch.task_type) <= NUM_TYPES);
  assign type_m1  = {{ADDR_W{1'b0}}, in_ch.task_type} - 1'b1;
  assign add_room = (ent_cnt != {COUNT_WIDTH{1'b1}}) && (total_r != {TOTAL_W{1'b1}});
  // strict > keeps the lowest index on ties
  assign cand     = (ent_tmr == '0) && (ent_cnt > best_cnt_r);
  assign last_idx = (scan_idx_r == ADDR_W'(NUM_TYPES - 1));
  assign scan_num = IDX_W'(scan_idx_r) + 1'b1;
  assign best_ext = {{TYPE_W{1'b0}}, best_r};
  assign out_free = !out_valid_r || out_ch.ready;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.chosen_type = out_type_r;
  assign out_ch.slot_count  = out_slots_r;
  assign out_ch.remaining   = out_total_r;
  assign out_ch.done_res    = out_done_r;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = scan_idx_r;
    ram_wdata = '0;
    ram_raddr = scan_idx_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire && in_ch.kind == cgts_pkg::KIND_ADD) begin
          ram_raddr = type_m1[ADDR_W-1:0];
        end else begin
          ram_raddr = '0;
        end
      end
      S_ADD: begin
        ram_waddr = add_addr_r;
        ram_we    = add_room;
        ram_wdata = {ent_cnt + 1'b1, ent_tmr};
      end
      S_SCAN: begin
        ram_we    = 1'b1;
        ram_waddr = scan_idx_r;
        ram_wdata = {ent_cnt, (ent_tmr != '0) ? ent_tmr - 1'b1 : ent_tmr};
        ram_raddr = scan_idx_r + 1'b1;
      end
      S_FIN: begin
        ram_we    = (best_r != '0);
        ram_waddr = ADDR_W'(best_r - 1'b1);
        ram_wdata = {best_cnt_r - 1'b1, cooldown_r};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cooldown_r  <= '0;
      total_r     <= '0;
      slots_r     <= '0;
      valid_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= valid_r[ram_raddr];
      if (ram_we) begin
        valid_r[ram_waddr] <= 1'b1;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        cooldown_r <= cfg_ch.data;
      end
      // S_EMIT reloads the output register itself
      if (out_valid_r && out_ch.ready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            best_r     <= '0;
            best_cnt_r <= '0;
            scan_idx_r <= '0;
            if (in_ch.kind == cgts_pkg::KIND_ADD) begin
              add_addr_r <= type_m1[ADDR_W-1:0];
              if (add_ok) begin
                state_r <= S_ADD;
              end
            end else if (total_r == '0) begin
              state_r <= S_EMIT;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_ADD: begin
          if (add_room) begin
            total_r <= total_r + 1'b1;
          end
          state_r <= S_IDLE;
        end
        S_SCAN: begin
          if (cand) begin
            best_r     <= scan_num;
            best_cnt_r <= ent_cnt;
          end
          scan_idx_r <= scan_idx_r + 1'b1;
          if (last_idx) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (best_r != '0) begin
            total_r <= total_r - 1'b1;
          end
          if (slots_r != {SLOT_W{1'b1}}) begin
            slots_r <= slots_r + 1'b1;
          end
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_type_r  <= best_ext[TYPE_W-1:0];
            out_slots_r <= slots_r;
            out_total_r <= total_r;
            out_done_r  <= (total_r == '0);
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== verif/cooldown_greedy_task_scheduler_tb.sv =====
`timescale 1ns / 1ps
module cooldown_greedy_task_scheduler_tb;

  localparam int NUM_TYPES     = 26;
  localparam int CNT_W         = 16;
  localparam int TYPE_W        = cgts_pkg::TYPE_W;
  localparam int TIMER_W       = cgts_pkg::TIMER_W;
  localparam int TOTAL_W       = cgts_pkg::TOTAL_W;
  localparam int SLOT_W        = cgts_pkg::SLOT_W;
  localparam int SETTLE_CYCLES = NUM_TYPES + 8;
  localparam int LIMIT_CYCLES  = 2_000_000;
  localparam int PHASE_ITEMS   = 330;

  typedef struct packed {
    logic [TYPE_W-1:0]  chosen;
    logic [SLOT_W-1:0]  slots;
    logic [TOTAL_W-1:0] left;
    logic               done;
  } slot_result_t;

  logic clk;
  logic rst_n;

  cgts_in_if  in_if ();
  cgts_out_if out_if ();
  cgts_cfg_if cfg_if ();

  cooldown_greedy_task_scheduler dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // scheduler state as the testbench sees it
  logic [CNT_W-1:0]   pend_cnt [NUM_TYPES];
  logic [TIMER_W-1:0] cd_left  [NUM_TYPES];
  logic [TOTAL_W-1:0] pend_total;
  logic [SLOT_W-1:0]  slots_run;
  logic [TIMER_W-1:0] cooldown_q;

  slot_result_t expected_slots[$];
  int mismatches;
  int cycles;
  int burst_left;
  bit no_gaps;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_slots.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    if (mismatches < 40)
      $display("mismatch at cycle %0d: %s", cycles, what);
    mismatches++;
  endtask

  // one add or tick, applied in acceptance order
  task automatic predict_slot(input cgts_pkg::kind_t k, input logic [TYPE_W-1:0] t);
    int idx;
    int pick;
    logic [CNT_W-1:0] top;
    slot_result_t r;
    idx = int'(t) - 1;
    pick = 0;
    top = '0;
    if (k == cgts_pkg::KIND_ADD) begin
      if (t >= 1 && t <= NUM_TYPES) begin
        if (pend_cnt[idx] != '1 && pend_total != '1) begin
          pend_cnt[idx]++;
          pend_total++;
        end
      end
    end else begin
      // nothing pending: no state moves, timers hold
      if (pend_total != 0) begin
        for (int i = 0; i < NUM_TYPES; i++) begin
          if (cd_left[i] == 0 && pend_cnt[i] > top) begin
            top = pend_cnt[i];
            pick = i + 1;
          end
        end
        if (pick != 0) begin
          pend_cnt[pick-1]--;
          pend_total--;
        end
        for (int i = 0; i < NUM_TYPES; i++)
          if (cd_left[i] != 0) cd_left[i]--;
        if (pick != 0) cd_left[pick-1] = cooldown_q;
        if (slots_run != '1) slots_run++;
      end
      r.chosen = pick[TYPE_W-1:0];
      r.slots  = slots_run;
      r.left   = pend_total;
      r.done   = (pend_total == 0);
      expected_slots.push_back(r);
    end
  endtask

  // source side: bursts of random length, random gaps between them
  task automatic send_item(input cgts_pkg::kind_t k, input logic [TYPE_W-1:0] t);
    int gap;
    if (!no_gaps && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    end
    in_if.valid     <= 1'b1;
    in_if.kind      <= k;
    in_if.task_type <= t;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    if (burst_left > 0) burst_left--;
    predict_slot(k, t);
  endtask

  // hold off the source until every expected result has come, then let an
  // add still in flight finish
  task automatic wait_drain();
    in_if.valid <= 1'b0;
    while (expected_slots.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cooldown(input logic [TIMER_W-1:0] v);
    wait_drain();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    cfg_if.valid <= 1'b0;
    cooldown_q = v;
  endtask

  // sink side: stall pattern changes mode every so often
  initial begin : out_stall
    int mode;
    int mode_left;
    int hold;
    mode = 0;
    mode_left = 0;
    hold = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(40, 200);
      end
      mode_left--;
      case (mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 3) != 0);
        2: out_if.ready <= (cycles % 3 != 0);
        default: begin
          if (hold == 0) begin
            hold = $urandom_range(5, 40);
            out_if.ready <= 1'b1;
          end else begin
            hold--;
            out_if.ready <= 1'b0;
          end
        end
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    slot_result_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_slots.size() == 0) begin
        report_mismatch($sformatf("unexpected result type %0d slots %0d",
                                  out_if.chosen_type, out_if.slot_count));
      end else begin
        e = expected_slots.pop_front();
        if (out_if.chosen_type !== e.chosen)
          report_mismatch($sformatf("chosen_type %0d, want %0d", out_if.chosen_type, e.chosen));
        if (out_if.slot_count !== e.slots)
          report_mismatch($sformatf("slot_count %0d, want %0d", out_if.slot_count, e.slots));
        if (out_if.remaining !== e.left)
          report_mismatch($sformatf("remaining %0d, want %0d", out_if.remaining, e.left));
        if (out_if.done_res !== e.done)
          report_mismatch($sformatf("done_res %0b, want %0b", out_if.done_res, e.done));
      end
    end
  end

  task automatic test_empty_tick();
    send_item(cgts_pkg::KIND_TICK, 5'd0);
    send_item(cgts_pkg::KIND_TICK, 5'd31);
  endtask

  task automatic test_bad_types();
    send_item(cgts_pkg::KIND_ADD, 5'd0);
    send_item(cgts_pkg::KIND_ADD, 5'd27);
    send_item(cgts_pkg::KIND_ADD, 5'd31);
    send_item(cgts_pkg::KIND_TICK, 5'd10);
  endtask

  // largest count wins, lowest type on ties, zero cooldown
  task automatic test_greedy_ties();
    send_item(cgts_pkg::KIND_ADD, 5'd26);
    send_item(cgts_pkg::KIND_ADD, 5'd1);
    send_item(cgts_pkg::KIND_ADD, 5'd13);
    send_item(cgts_pkg::KIND_ADD, 5'd13);
    repeat (5) send_item(cgts_pkg::KIND_TICK, 5'd0);
  endtask

  // types 3 and 4 only: idle slots while they cool down
  task automatic test_cooldown_idle();
    write_cooldown(8'd2);
    repeat (3) send_item(cgts_pkg::KIND_ADD, 5'd3);
    send_item(cgts_pkg::KIND_ADD, 5'd4);
    repeat (8) send_item(cgts_pkg::KIND_TICK, 5'd21);
  endtask

  task automatic test_random_phase(input logic [TIMER_W-1:0] cd);
    int sent;
    int n;
    int m;
    bit few;
    bit paused;
    sent = 0;
    paused = 0;
    write_cooldown(cd);
    while (sent < PHASE_ITEMS) begin
      if ($urandom_range(0, 9) < 7) begin
        // a batch of adds, then a run of ticks
        n = $urandom_range(1, 12);
        few = ($urandom_range(0, 1) == 1);
        repeat (n)
          send_item(cgts_pkg::KIND_ADD,
                    TYPE_W'(few ? $urandom_range(1, 4) : $urandom_range(1, NUM_TYPES)));
        m = $urandom_range(1, n + 4);
        repeat (m) send_item(cgts_pkg::KIND_TICK, TYPE_W'($urandom_range(0, 31)));
        sent += n + m;
      end else begin
        send_item(cgts_pkg::kind_t'($urandom_range(0, 1)), TYPE_W'($urandom_range(0, 31)));
        sent++;
      end
      if (!paused && sent >= PHASE_ITEMS / 2) begin
        wait_drain();
        paused = 1;
      end
    end
  endtask

  // adds and ticks with no gaps on the source side
  task automatic test_back_to_back();
    no_gaps = 1;
    repeat (16) send_item(cgts_pkg::KIND_ADD, TYPE_W'($urandom_range(1, NUM_TYPES)));
    repeat (12) send_item(cgts_pkg::KIND_TICK, 5'd0);
    no_gaps = 0;
  endtask

  initial begin : stimulus
    for (int i = 0; i < NUM_TYPES; i++) begin
      pend_cnt[i] = '0;
      cd_left[i]  = '0;
    end
    pend_total = '0;
    slots_run  = '0;
    cooldown_q = '0;
    mismatches = 0;
    cycles     = 0;
    burst_left = 0;
    no_gaps    = 0;
    rst_n           <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.kind      <= cgts_pkg::KIND_ADD;
    in_if.task_type <= '0;
    cfg_if.valid    <= 1'b0;
    cfg_if.data     <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_tick();
    test_bad_types();
    test_greedy_ties();
    test_cooldown_idle();
    test_random_phase(8'd0);
    test_random_phase(8'd255);
    test_random_phase(8'd1);
    test_random_phase(TIMER_W'($urandom_range(2, 30)));
    test_random_phase(8'd3);
    test_back_to_back();

    wait_drain();
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== cooldown_greedy_task_scheduler.f =====
rtl/cgts_pkg.sv
rtl/cgts_in_if.sv
rtl/cgts_out_if.sv
rtl/cgts_cfg_if.sv
rtl/cgts_ram.sv
rtl/cooldown_greedy_task_scheduler.sv
verif/cooldown_greedy_task_scheduler_tb.sv
